/* src/hrr_pkg.sv */
// Shared types, codes and constants for the health-aware round-robin backend pool.
`timescale 1ns / 1ps

package hrr_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam logic [7:0]  THRESHOLD_RST = 8'd3;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned SLOT_IN_W = 3;
  localparam int unsigned STREAK_W  = 8;
  localparam int unsigned ACTIVE_W  = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned ASUM_W    = 19;
  localparam int unsigned TSUM_W    = 35;
  localparam int unsigned UPOUT_W   = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CHOOSE      = 3'd0,
    FUNC_RELEASE     = 3'd1,
    FUNC_HEALTH_PASS = 3'd2,
    FUNC_HEALTH_FAIL = 3'd3,
    FUNC_READ_SLOT   = 3'd4,
    FUNC_READ_TOTALS = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_SUM,
    ST_SUM_LAST,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [STREAK_W-1:0] streak;
    logic [ACTIVE_W-1:0] active;
    logic [TOTAL_W-1:0]  requests;
    logic [TOTAL_W-1:0]  failures;
  } slot_t;

  typedef struct packed {
    logic [ASUM_W-1:0] active;
    logic [TSUM_W-1:0] requests;
    logic [TSUM_W-1:0] failures;
  } acc_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                failed;
    logic [STREAK_W-1:0] threshold;
  } upd_ctrl_t;

  typedef struct packed {
    logic                 status;
    logic [SLOT_IN_W-1:0] chosen_slot;
    logic                 old_up;
    logic                 new_up;
    logic [STREAK_W-1:0]  fail_streak;
    logic [ASUM_W-1:0]    active;
    logic [TSUM_W-1:0]    requests;
    logic [TSUM_W-1:0]    failures;
  } res_t;

endpackage

/* src/health_aware_round_robin_pool.sv */
// Health-aware round-robin backend pool: sequencer, slot state and result register.
// A choose with no slot up, an out-of-range slot or an unused code goes straight to the finish
// state; release, health and read slot pass through an update state; a choose first scans the
// slots from the pointer to the first one up; read totals sums every slot in turn.
// A new item is taken only once the last result is loaded, which a stalled result output holds off.
// Reset sets every slot up with zero counters, the pointer to 0 and the threshold to 3.
`timescale 1ns / 1ps

module health_aware_round_robin_pool #(
  parameter int unsigned NUM_SLOTS = hrr_pkg::NUM_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hrr_pkg::STREAK_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hrr_pkg::FUNC_W-1:0]      func_i,
  input  logic [hrr_pkg::SLOT_IN_W-1:0]   backend_slot_i,
  input  logic                            failed_flag_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            status_o,
  output logic [hrr_pkg::SLOT_IN_W-1:0]   chosen_slot_o,
  output logic                            old_up_o,
  output logic                            new_up_o,
  output logic [hrr_pkg::STREAK_W-1:0]    fail_streak_o,
  output logic [hrr_pkg::ASUM_W-1:0]      active_out_o,
  output logic [hrr_pkg::TSUM_W-1:0]      requests_out_o,
  output logic [hrr_pkg::TSUM_W-1:0]      failures_out_o,
  output logic [hrr_pkg::UPOUT_W-1:0]     slots_up_o
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned UPC_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  hrr_pkg::state_e state_q, state_d;
  logic [SLOT_W-1:0]           idx_q, idx_d;
  logic [SLOT_W-1:0]           ptr_q, ptr_d;
  logic [hrr_pkg::FUNC_W-1:0]  func_q, func_d;
  logic                        failed_q, failed_d;
  logic [hrr_pkg::STREAK_W-1:0] thr_q;
  logic [NUM_SLOTS-1:0]        up_q, up_d;
  logic [UPC_W-1:0]            up_cnt_q, up_cnt_d;
  logic                        sum_vld_q, sum_vld_d;
  hrr_pkg::acc_t               acc_q, acc_d;
  hrr_pkg::res_t               res_q, res_d;
  hrr_pkg::res_t               out_q;
  logic [UPC_W-1:0]            out_up_cnt_q;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  logic [SLOT_W-1:0]           in_idx;
  logic [SLOT_W-1:0]           idx_next;
  logic [SLOT_W-1:0]           rd_addr;
  logic                        mem_we;
  logic                        slot_oob;
  hrr_pkg::slot_t              rd_entry;
  hrr_pkg::slot_t              new_entry;
  hrr_pkg::upd_ctrl_t          upd_ctrl;
  hrr_pkg::acc_t               acc_sum;
  logic                        up_old;
  logic                        up_new;

  assign in_idx   = SLOT_W'(backend_slot_i);
  assign idx_next = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
  assign slot_oob = (32'(backend_slot_i) >= NUM_SLOTS);
  assign up_old   = up_q[idx_q];
  assign rd_addr  = (state_q == hrr_pkg::ST_IDLE) ? in_idx : idx_q;

  assign upd_ctrl.func      = func_q;
  assign upd_ctrl.failed    = failed_q;
  assign upd_ctrl.threshold = thr_q;

  hrr_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (idx_q),
    .wr_data_i (new_entry),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_entry)
  );

  hrr_upd_unit u_upd_unit (
    .ctrl_i  (upd_ctrl),
    .up_i    (up_old),
    .entry_i (rd_entry),
    .acc_i   (acc_q),
    .entry_o (new_entry),
    .up_o    (up_new),
    .acc_o   (acc_sum)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != hrr_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    func_d    = func_q;
    failed_d  = failed_q;
    up_d      = up_q;
    up_cnt_d  = up_cnt_q;
    sum_vld_d = sum_vld_q;
    acc_d     = acc_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      hrr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          failed_d  = failed_flag_i;
          res_d     = '0;
          acc_d     = '0;
          sum_vld_d = 1'b0;
          if (func_i == hrr_pkg::FUNC_CHOOSE) begin
            if (up_cnt_q == '0) begin
              res_d.status = 1'b1;
              state_d      = hrr_pkg::ST_FINISH;
            end else begin
              idx_d   = ptr_q;
              state_d = hrr_pkg::ST_SCAN;
            end
          end else if (func_i inside {hrr_pkg::FUNC_RELEASE, hrr_pkg::FUNC_HEALTH_PASS,
                                      hrr_pkg::FUNC_HEALTH_FAIL, hrr_pkg::FUNC_READ_SLOT}) begin
            if (slot_oob) begin
              res_d.status      = 1'b1;
              res_d.chosen_slot = backend_slot_i;
              state_d           = hrr_pkg::ST_FINISH;
            end else begin
              idx_d   = in_idx;
              state_d = hrr_pkg::ST_UPDATE;
            end
          end else if (func_i == hrr_pkg::FUNC_READ_TOTALS) begin
            idx_d   = '0;
            state_d = hrr_pkg::ST_SUM;
          end else begin
            state_d = hrr_pkg::ST_FINISH;
          end
        end
      end
      hrr_pkg::ST_SCAN: begin
        if (up_old) begin
          state_d = hrr_pkg::ST_UPDATE;
        end else begin
          idx_d = idx_next;
        end
      end
      hrr_pkg::ST_UPDATE: begin
        mem_we      = 1'b1;
        up_d[idx_q] = up_new;
        if (up_old && !up_new) begin
          up_cnt_d = up_cnt_q - 1'b1;
        end else if (!up_old && up_new) begin
          up_cnt_d = up_cnt_q + 1'b1;
        end
        if (func_q == hrr_pkg::FUNC_CHOOSE) begin
          ptr_d = idx_next;
        end
        res_d.status      = 1'b0;
        res_d.chosen_slot = hrr_pkg::SLOT_IN_W'(idx_q);
        res_d.old_up      = up_old;
        res_d.new_up      = up_new;
        res_d.fail_streak = new_entry.streak;
        res_d.active      = hrr_pkg::ASUM_W'(new_entry.active);
        res_d.requests    = hrr_pkg::TSUM_W'(new_entry.requests);
        res_d.failures    = hrr_pkg::TSUM_W'(new_entry.failures);
        state_d           = hrr_pkg::ST_FINISH;
      end
      hrr_pkg::ST_SUM: begin
        if (sum_vld_q) begin
          acc_d = acc_sum;
        end
        sum_vld_d = 1'b1;
        if (idx_q == LAST_SLOT) begin
          state_d = hrr_pkg::ST_SUM_LAST;
        end else begin
          idx_d = idx_next;
        end
      end
      hrr_pkg::ST_SUM_LAST: begin
        acc_d          = acc_sum;
        res_d.active   = acc_sum.active;
        res_d.requests = acc_sum.requests;
        res_d.failures = acc_sum.failures;
        state_d        = hrr_pkg::ST_FINISH;
      end
      hrr_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = hrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hrr_pkg::ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrr_pkg::ST_IDLE;
      ptr_q       <= '0;
      thr_q       <= hrr_pkg::THRESHOLD_RST;
      up_q        <= '1;
      up_cnt_q    <= UPC_W'(NUM_SLOTS);
      sum_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      up_q        <= up_d;
      up_cnt_q    <= up_cnt_d;
      sum_vld_q   <= sum_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    func_q   <= func_d;
    failed_q <= failed_d;
    acc_q    <= acc_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q        <= res_q;
      out_up_cnt_q <= up_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign chosen_slot_o  = out_q.chosen_slot;
  assign old_up_o       = out_q.old_up;
  assign new_up_o       = out_q.new_up;
  assign fail_streak_o  = out_q.fail_streak;
  assign active_out_o   = out_q.active;
  assign requests_out_o = out_q.requests;
  assign failures_out_o = out_q.failures;
  assign slots_up_o     = hrr_pkg::UPOUT_W'(out_up_cnt_q);

endmodule

/* src/hrr_slot_mem.sv */
// Slot counter memory with per-entry valid bits so that unwritten entries read as zero.
`timescale 1ns / 1ps

module hrr_slot_mem #(
  parameter int unsigned NUM_SLOTS = hrr_pkg::NUM_SLOTS_DEF,
  parameter int unsigned SLOT_W    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  hrr_pkg::slot_t    wr_data_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output hrr_pkg::slot_t    rd_data_o
);

  hrr_pkg::slot_t       mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  hrr_pkg::slot_t       rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* src/hrr_upd_unit.sv */
// Shared saturating update and accumulate unit for one slot entry.
`timescale 1ns / 1ps

module hrr_upd_unit (
  input  hrr_pkg::upd_ctrl_t ctrl_i,
  input  logic               up_i,
  input  hrr_pkg::slot_t     entry_i,
  input  hrr_pkg::acc_t      acc_i,
  output hrr_pkg::slot_t     entry_o,
  output logic               up_o,
  output hrr_pkg::acc_t      acc_o
);

  logic [hrr_pkg::STREAK_W-1:0] streak_inc;
  logic [hrr_pkg::ACTIVE_W-1:0] active_inc;
  logic [hrr_pkg::ACTIVE_W-1:0] active_dec;
  logic [hrr_pkg::TOTAL_W-1:0]  req_inc;
  logic [hrr_pkg::TOTAL_W-1:0]  fail_inc;

  always_comb begin
    streak_inc = (&entry_i.streak) ? entry_i.streak : entry_i.streak + 1'b1;
    active_inc = (&entry_i.active) ? entry_i.active : entry_i.active + 1'b1;
    active_dec = (entry_i.active == '0) ? entry_i.active : entry_i.active - 1'b1;
    req_inc    = (&entry_i.requests) ? entry_i.requests : entry_i.requests + 1'b1;
    fail_inc   = (&entry_i.failures) ? entry_i.failures : entry_i.failures + 1'b1;

    entry_o = entry_i;
    up_o    = up_i;
    case (ctrl_i.func)
      hrr_pkg::FUNC_CHOOSE: begin
        entry_o.active   = active_inc;
        entry_o.requests = req_inc;
      end
      hrr_pkg::FUNC_RELEASE: begin
        entry_o.active = active_dec;
        if (ctrl_i.failed) begin
          entry_o.failures = fail_inc;
        end
      end
      hrr_pkg::FUNC_HEALTH_PASS: begin
        entry_o.streak = '0;
        up_o           = 1'b1;
      end
      hrr_pkg::FUNC_HEALTH_FAIL: begin
        entry_o.streak = streak_inc;
        if (streak_inc >= ctrl_i.threshold) begin
          up_o = 1'b0;
        end
      end
      default: begin
        entry_o = entry_i;
      end
    endcase

    acc_o.active   = acc_i.active + hrr_pkg::ASUM_W'(entry_i.active);
    acc_o.requests = acc_i.requests + hrr_pkg::TSUM_W'(entry_i.requests);
    acc_o.failures = acc_i.failures + hrr_pkg::TSUM_W'(entry_i.failures);
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the health-aware round-robin backend pool.
`timescale 1ns / 1ps

module tb;

  localparam int N = hrr_pkg::NUM_SLOTS_DEF;
  localparam int unsigned SLOT_IN_W = hrr_pkg::SLOT_IN_W;
  localparam int unsigned STREAK_W  = hrr_pkg::STREAK_W;
  localparam int unsigned ACTIVE_W  = hrr_pkg::ACTIVE_W;
  localparam int unsigned TOTAL_W   = hrr_pkg::TOTAL_W;
  localparam int unsigned ASUM_W    = hrr_pkg::ASUM_W;
  localparam int unsigned TSUM_W    = hrr_pkg::TSUM_W;
  localparam int unsigned UPOUT_W   = hrr_pkg::UPOUT_W;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                 status;
    logic [SLOT_IN_W-1:0] chosen_slot;
    logic                 old_up;
    logic                 new_up;
    logic [STREAK_W-1:0]  fail_streak;
    logic [ASUM_W-1:0]    active;
    logic [TSUM_W-1:0]    requests;
    logic [TSUM_W-1:0]    failures;
    logic [UPOUT_W-1:0]   slots_up;
  } pool_result_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [STREAK_W-1:0]  cfg_val;
    hrr_pkg::func_e       func;
    logic [SLOT_IN_W-1:0] slot;
    logic                 failed;
    bit                   typed;
    pool_result_t         want;
  } step_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [STREAK_W-1:0]   cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  hrr_pkg::func_e        func_i = hrr_pkg::FUNC_CHOOSE;
  logic [SLOT_IN_W-1:0]  backend_slot_i = '0;
  logic                  failed_flag_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  status_o;
  logic [SLOT_IN_W-1:0]  chosen_slot_o;
  logic                  old_up_o;
  logic                  new_up_o;
  logic [STREAK_W-1:0]   fail_streak_o;
  logic [ASUM_W-1:0]     active_out_o;
  logic [TSUM_W-1:0]     requests_out_o;
  logic [TSUM_W-1:0]     failures_out_o;
  logic [UPOUT_W-1:0]    slots_up_o;

  logic                  up_now [N];
  logic [STREAK_W-1:0]   streak_now [N];
  logic [ACTIVE_W-1:0]   active_now [N];
  logic [TOTAL_W-1:0]    requests_now [N];
  logic [TOTAL_W-1:0]    failures_now [N];
  logic [SLOT_IN_W-1:0]  rr_ptr = '0;
  logic [STREAK_W-1:0]   threshold_now = hrr_pkg::THRESHOLD_RST;

  pool_result_t          pending_results [$];
  step_row_t             directed_steps [$];
  int                    idle_pct = 11;
  int                    stall_pct = 11;
  int                    cycle_count = 0;
  bit                    failed_any = 1'b0;

  health_aware_round_robin_pool u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .backend_slot_i (backend_slot_i),
    .failed_flag_i  (failed_flag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .chosen_slot_o  (chosen_slot_o),
    .old_up_o       (old_up_o),
    .new_up_o       (new_up_o),
    .fail_streak_o  (fail_streak_o),
    .active_out_o   (active_out_o),
    .requests_out_o (requests_out_o),
    .failures_out_o (failures_out_o),
    .slots_up_o     (slots_up_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < N; i++) begin
      up_now[i] = 1'b1;
      streak_now[i] = '0;
      active_now[i] = '0;
      requests_now[i] = '0;
      failures_now[i] = '0;
    end
  end

  function automatic pool_result_t pool_apply(hrr_pkg::func_e f, logic [SLOT_IN_W-1:0] s,
                                              logic fl);
    pool_result_t r;
    int sel;
    bit slot_res;
    bit found;
    logic old;
    longint unsigned sum_a, sum_r, sum_f;
    int ups;
    r = '0;
    sel = s;
    slot_res = 1'b0;
    found = 1'b0;
    old = 1'b0;
    sum_a = 0;
    sum_r = 0;
    sum_f = 0;
    ups = 0;
    case (f)
      hrr_pkg::FUNC_CHOOSE: begin
        for (int i = 0; i < N && !found; i++) begin
          sel = (int'(rr_ptr) + i) % N;
          if (up_now[sel]) begin
            found = 1'b1;
            if (active_now[sel] != '1) active_now[sel]++;
            if (requests_now[sel] != '1) requests_now[sel]++;
            rr_ptr = SLOT_IN_W'((sel + 1) % N);
          end
        end
        slot_res = found;
        old = 1'b1;
        r.status = !found;
      end
      hrr_pkg::FUNC_RELEASE: begin
        old = up_now[sel];
        if (active_now[sel] != '0) active_now[sel]--;
        if (fl && failures_now[sel] != '1) failures_now[sel]++;
        slot_res = 1'b1;
      end
      hrr_pkg::FUNC_HEALTH_PASS: begin
        old = up_now[sel];
        streak_now[sel] = '0;
        up_now[sel] = 1'b1;
        slot_res = 1'b1;
      end
      hrr_pkg::FUNC_HEALTH_FAIL: begin
        old = up_now[sel];
        if (streak_now[sel] != '1) streak_now[sel]++;
        if (streak_now[sel] >= threshold_now) up_now[sel] = 1'b0;
        slot_res = 1'b1;
      end
      hrr_pkg::FUNC_READ_SLOT: begin
        old = up_now[sel];
        slot_res = 1'b1;
      end
      hrr_pkg::FUNC_READ_TOTALS: begin
        for (int i = 0; i < N; i++) begin
          sum_a += active_now[i];
          sum_r += requests_now[i];
          sum_f += failures_now[i];
        end
        r.active = ASUM_W'(sum_a);
        r.requests = TSUM_W'(sum_r);
        r.failures = TSUM_W'(sum_f);
      end
      default: ;
    endcase
    if (slot_res) begin
      r.chosen_slot = SLOT_IN_W'(sel);
      r.old_up = old;
      r.new_up = up_now[sel];
      r.fail_streak = streak_now[sel];
      r.active = ASUM_W'(active_now[sel]);
      r.requests = TSUM_W'(requests_now[sel]);
      r.failures = TSUM_W'(failures_now[sel]);
    end
    for (int i = 0; i < N; i++) ups += up_now[i];
    r.slots_up = UPOUT_W'(ups);
    return r;
  endfunction

  task automatic send_item(hrr_pkg::func_e f, logic [SLOT_IN_W-1:0] s, logic fl,
                           bit typed = 1'b0, pool_result_t want = '0);
    pool_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    backend_slot_i <= s;
    failed_flag_i <= fl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = pool_apply(f, s, fl);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_threshold(logic [STREAK_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold_now = v;
  endtask

  task automatic add_step(hrr_pkg::func_e f, logic [SLOT_IN_W-1:0] s, logic fl,
                          bit typed = 1'b0, pool_result_t want = '0);
    directed_steps.push_back(step_row_t'{1'b0, 8'd0, f, s, fl, typed, want});
  endtask

  task automatic add_cfg(logic [STREAK_W-1:0] v);
    directed_steps.push_back(step_row_t'{1'b1, v, hrr_pkg::FUNC_CHOOSE, 3'd0, 1'b0, 1'b0,
                                         '0});
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      failed_any = 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    pool_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        failed_any = 1'b1;
        $display("%0t: result beat with no expectation pending", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("chosen_slot", want.chosen_slot, chosen_slot_o);
        check_field("old_up", want.old_up, old_up_o);
        check_field("new_up", want.new_up, new_up_o);
        check_field("fail_streak", want.fail_streak, fail_streak_o);
        check_field("active_out", want.active, active_out_o);
        check_field("requests_out", want.requests, requests_out_o);
        check_field("failures_out", want.failures, failures_out_o);
        check_field("slots_up", want.slots_up, slots_up_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [STREAK_W-1:0] phase_thr [8];
    logic [STREAK_W-1:0] thr_v;
    logic [SLOT_IN_W-1:0] sat_slot;
    step_row_t row;
    int done;
    int r;
    phase_thr = '{8'd255, 8'd3, 8'd1, 8'd2, 8'd0, 8'd128, 8'd1, 8'd0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fields: status, slot, old_up, new_up, streak, active, requests, failures, slots_up.
    add_step(hrr_pkg::FUNC_READ_TOTALS, 3'd0, 1'b0, 1,
             pool_result_t'{1'b0, 3'd0, 1'b0, 1'b0, 8'd0, 19'd0, 35'd0, 35'd0, 4'd8});
    add_step(hrr_pkg::FUNC_READ_SLOT, 3'd7, 1'b1, 1,
             pool_result_t'{1'b0, 3'd7, 1'b1, 1'b1, 8'd0, 19'd0, 35'd0, 35'd0, 4'd8});
    add_step(hrr_pkg::FUNC_CHOOSE, 3'd5, 1'b0, 1,
             pool_result_t'{1'b0, 3'd0, 1'b1, 1'b1, 8'd0, 19'd1, 35'd1, 35'd0, 4'd8});
    add_step(hrr_pkg::FUNC_CHOOSE, 3'd0, 1'b1, 1,
             pool_result_t'{1'b0, 3'd1, 1'b1, 1'b1, 8'd0, 19'd1, 35'd1, 35'd0, 4'd8});
    add_step(hrr_pkg::FUNC_RELEASE, 3'd0, 1'b1, 1,
             pool_result_t'{1'b0, 3'd0, 1'b1, 1'b1, 8'd0, 19'd0, 35'd1, 35'd1, 4'd8});
    add_step(hrr_pkg::FUNC_RELEASE, 3'd0, 1'b0, 1,
             pool_result_t'{1'b0, 3'd0, 1'b1, 1'b1, 8'd0, 19'd0, 35'd1, 35'd1, 4'd8});
    add_step(hrr_pkg::FUNC_HEALTH_FAIL, 3'd2, 1'b0, 1,
             pool_result_t'{1'b0, 3'd2, 1'b1, 1'b1, 8'd1, 19'd0, 35'd0, 35'd0, 4'd8});
    add_step(hrr_pkg::FUNC_HEALTH_FAIL, 3'd2, 1'b1);
    add_step(hrr_pkg::FUNC_HEALTH_FAIL, 3'd2, 1'b0, 1,
             pool_result_t'{1'b0, 3'd2, 1'b1, 1'b0, 8'd3, 19'd0, 35'd0, 35'd0, 4'd7});
    add_step(hrr_pkg::FUNC_HEALTH_FAIL, 3'd2, 1'b0);
    add_step(hrr_pkg::FUNC_CHOOSE, 3'd0, 1'b0, 1,
             pool_result_t'{1'b0, 3'd3, 1'b1, 1'b1, 8'd0, 19'd1, 35'd1, 35'd0, 4'd7});
    add_step(hrr_pkg::FUNC_HEALTH_PASS, 3'd2, 1'b0, 1,
             pool_result_t'{1'b0, 3'd2, 1'b0, 1'b1, 8'd0, 19'd0, 35'd0, 35'd0, 4'd8});
    add_cfg(8'd1);
    for (int s = 0; s < N; s++) add_step(hrr_pkg::FUNC_HEALTH_FAIL, SLOT_IN_W'(s), 1'b0);
    add_step(hrr_pkg::FUNC_CHOOSE, 3'd0, 1'b0, 1,
             pool_result_t'{1'b1, 3'd0, 1'b0, 1'b0, 8'd0, 19'd0, 35'd0, 35'd0, 4'd0});
    add_step(hrr_pkg::FUNC_READ_TOTALS, 3'd7, 1'b1, 1,
             pool_result_t'{1'b0, 3'd0, 1'b0, 1'b0, 8'd0, 19'd2, 35'd3, 35'd1, 4'd0});
    add_step(hrr_pkg::FUNC_HEALTH_PASS, 3'd7, 1'b1, 1,
             pool_result_t'{1'b0, 3'd7, 1'b0, 1'b1, 8'd0, 19'd0, 35'd0, 35'd0, 4'd1});
    add_step(hrr_pkg::FUNC_CHOOSE, 3'd0, 1'b0, 1,
             pool_result_t'{1'b0, 3'd7, 1'b1, 1'b1, 8'd0, 19'd1, 35'd1, 35'd0, 4'd1});

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_cfg) write_threshold(row.cfg_val);
      else send_item(row.func, row.slot, row.failed, row.typed, row.want);
    end

    for (int p = 0; p < 8; p++) begin
      thr_v = (p == 5) ? STREAK_W'($urandom_range(4, 20)) :
              (p == 7) ? STREAK_W'($urandom_range(1, 255)) : phase_thr[p];
      write_threshold(thr_v);
      idle_pct = (p == 1) ? 0 : 11;
      stall_pct = (p == 1) ? 0 : 11;
      if (p == 0) begin
        // Drive one slot's failure streak into saturation, which takes it down, then bring it back up.
        sat_slot = SLOT_IN_W'($urandom_range(0, N - 1));
        repeat (258) send_item(hrr_pkg::FUNC_HEALTH_FAIL, sat_slot, 1'($urandom_range(0, 1)));
        send_item(hrr_pkg::FUNC_HEALTH_PASS, sat_slot, 1'b0);
      end
      done = 0;
      while (done < 165) begin
        r = $urandom_range(0, 99);
        if (thr_v <= 2 && $urandom_range(0, 99) < 3) begin
          // Unless the threshold is zero, take the whole pool down, then ask for a backend.
          for (int s = 0; s < N; s++) begin
            repeat (thr_v) send_item(hrr_pkg::FUNC_HEALTH_FAIL, SLOT_IN_W'(s), 1'b0);
          end
          send_item(hrr_pkg::FUNC_CHOOSE, SLOT_IN_W'($urandom_range(0, N - 1)), 1'b0);
          done += N * thr_v + 1;
        end else begin
          send_item(r < 36 ? hrr_pkg::FUNC_CHOOSE :
                    r < 60 ? hrr_pkg::FUNC_RELEASE :
                    r < 72 ? hrr_pkg::FUNC_HEALTH_PASS :
                    r < 86 ? hrr_pkg::FUNC_HEALTH_FAIL :
                    r < 94 ? hrr_pkg::FUNC_READ_SLOT : hrr_pkg::FUNC_READ_TOTALS,
                    SLOT_IN_W'($urandom_range(0, N - 1)), 1'($urandom_range(0, 1)));
          done++;
        end
      end
    end

    in_valid_i <= 1'b0;
    idle_pct = 11;
    stall_pct = 11;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (N + 8) @(posedge clk_i);
    if (!failed_any) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/hrr_pkg.sv
src/hrr_slot_mem.sv
src/hrr_upd_unit.sv
src/health_aware_round_robin_pool.sv
tb/sv/tb.sv
